@@ hw/rtl/ppds_pkg.sv @@
// ----------------------------------------------------------------------------
// ppds_pkg
// shared types, constants and channel helpers of the pressure profile
// dac sequencer
// ----------------------------------------------------------------------------
package ppds_pkg;

  localparam int unsigned PRESS_W    = 12;
  localparam int unsigned SECONDS_W  = 8;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned HB_W       = 5;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned SEL_LOW_W  = 8;
  localparam int unsigned SEL_HIGH_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CH_W-1:0]   PRESSURE_CH = CH_W'(7);
  localparam logic [CH_W-1:0]   FIXED_CH    = CH_W'(8);
  localparam logic [CH_W-1:0]   LOW_SPLIT   = CH_W'(4);
  localparam logic [CH_W-1:0]   HIGH_FIRST  = CH_W'(7);
  localparam logic [CH_W-1:0]   HIGH_END    = CH_W'(14);
  localparam logic [VAL_W-1:0]  FIXED_VALUE = VAL_W'(3500);
  localparam logic [VAL_W-1:0]  IDLE_VALUE  = 16'hFFFF;
  localparam logic [PRESS_W-1:0] BASE_RESET = PRESS_W'(3850);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_PRESSURE = 3'd0,
    REG_TOP_PRESSURE  = 3'd1,
    REG_MID_PRESSURE  = 3'd2,
    REG_LOW_PRESSURE  = 3'd3,
    REG_MID_SECONDS   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    logic               heartbeat;
  } tick_t;

  function automatic logic [VAL_W-1:0] want_value(input logic [CH_W-1:0] ch,
                                                  input logic [PRESS_W-1:0] pressure);
    logic [VAL_W-1:0] v;
    v = IDLE_VALUE;
    if (ch == PRESSURE_CH) begin
      v = VAL_W'(pressure);
    end else if (ch == FIXED_CH) begin
      v = FIXED_VALUE;
    end
    return v;
  endfunction

  function automatic logic [SEL_LOW_W-1:0] sel_low(input logic [CH_W-1:0] ch);
    logic [SEL_LOW_W-1:0] s;
    s = '0;
    if (ch < LOW_SPLIT) begin
      s = SEL_LOW_W'(1) << ch;
    end else if (ch < HIGH_FIRST) begin
      s = SEL_LOW_W'(1) << (ch + CH_W'(1));
    end
    return s;
  endfunction

  function automatic logic [SEL_HIGH_W-1:0] sel_high(input logic [CH_W-1:0] ch);
    logic [SEL_HIGH_W-1:0] s;
    s = '0;
    if (ch >= HIGH_FIRST && ch < HIGH_END) begin
      s = SEL_HIGH_W'(1) << (ch - HIGH_FIRST);
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/ppds_front.sv @@
// ----------------------------------------------------------------------------
// ppds_front
// takes ticks and register writes, advances heartbeat and pressure phase,
// hands the chosen pressure and heartbeat level to the queue
// ----------------------------------------------------------------------------
module ppds_front #(
  parameter int unsigned TICKS_PER_SECOND = 80,
  parameter int unsigned HEARTBEAT_TICKS  = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_valid_i,
  input  logic                              start_req_i,
  input  logic                              reset_req_i,
  output logic                              tick_ready_o,
  input  logic                              cfg_valid_i,
  input  logic [ppds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppds_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              push_o,
  output ppds_pkg::tick_t                   entry_o,
  input  logic                              full_i
);
  import ppds_pkg::*;

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_HIGH = 2'd1,
    PH_MID  = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  logic [PRESS_W-1:0]   base_q, top_q, mid_q, low_q;
  logic [SECONDS_W-1:0] mid_sec_q;
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     cd_q, cd_d;
  logic [HB_W-1:0]      hb_cnt_q, hb_cnt_d;
  logic                 hb_lvl_q, hb_lvl_d;
  logic [PRESS_W-1:0]   pressure;
  logic                 accept;

  assign tick_ready_o = !full_i;
  assign accept       = tick_valid_i && !full_i;

  always_comb begin
    if (hb_cnt_q >= HB_W'(HEARTBEAT_TICKS)) begin
      hb_cnt_d = '0;
      hb_lvl_d = !hb_lvl_q;
    end else begin
      hb_cnt_d = hb_cnt_q + HB_W'(1);
      hb_lvl_d = hb_lvl_q;
    end

    phase_d = phase_q;
    cd_d    = cd_q;
    if (start_req_i) begin
      phase_d = PH_HIGH;
      cd_d    = CNT_W'(2 * TICKS_PER_SECOND);
    end
    if (reset_req_i) begin
      phase_d = PH_BASE;
    end

    pressure = base_q;
    unique case (phase_d)
      PH_HIGH: begin
        pressure = top_q;
        if (cd_d == '0) begin
          phase_d = PH_MID;
          cd_d    = CNT_W'(mid_sec_q) * CNT_W'(TICKS_PER_SECOND);
        end
      end
      PH_MID: begin
        pressure = mid_q;
        if (cd_d == '0) begin
          phase_d = PH_LOW;
        end
      end
      PH_LOW:  pressure = low_q;
      default: pressure = base_q;
    endcase
    if (cd_d != '0) begin
      cd_d = cd_d - CNT_W'(1);
    end
  end

  assign push_o           = accept;
  assign entry_o.pressure = pressure;
  assign entry_o.heartbeat = hb_lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_RESET;
      top_q     <= '0;
      mid_q     <= '0;
      low_q     <= '0;
      mid_sec_q <= '0;
      phase_q   <= PH_BASE;
      cd_q      <= '0;
      hb_cnt_q  <= '0;
      hb_lvl_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_BASE_PRESSURE: base_q    <= cfg_data_i[PRESS_W-1:0];
          REG_TOP_PRESSURE:  top_q     <= cfg_data_i[PRESS_W-1:0];
          REG_MID_PRESSURE:  mid_q     <= cfg_data_i[PRESS_W-1:0];
          REG_LOW_PRESSURE:  low_q     <= cfg_data_i[PRESS_W-1:0];
          REG_MID_SECONDS:   mid_sec_q <= cfg_data_i[SECONDS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q  <= phase_d;
        cd_q     <= cd_d;
        hb_cnt_q <= hb_cnt_d;
        hb_lvl_q <= hb_lvl_d;
      end
    end
  end

endmodule

@@ hw/rtl/ppds_queue.sv @@
// ----------------------------------------------------------------------------
// ppds_queue
// two-entry queue between the tick front end and the channel scanner
// ----------------------------------------------------------------------------
module ppds_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppds_pkg::tick_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output ppds_pkg::tick_t head_o,
  output logic            empty_o
);
  import ppds_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tick_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/ppds_back.sv @@
// ----------------------------------------------------------------------------
// ppds_back
// compares all channels against the last written values, then sends one
// dac write per changed channel in channel order, or one status result
// ----------------------------------------------------------------------------
module ppds_back #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  ppds_pkg::tick_t                    head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_write_o,
  output logic [ppds_pkg::CH_W-1:0]          out_channel_o,
  output logic [ppds_pkg::SEL_LOW_W-1:0]     out_sel_low_o,
  output logic [ppds_pkg::SEL_HIGH_W-1:0]    out_sel_high_o,
  output logic [ppds_pkg::PRESS_W-1:0]       out_value_o,
  output logic                               out_heartbeat_o,
  output logic                               out_last_o
);
  import ppds_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_CHANNELS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                   state_q;
  logic [VAL_W-1:0]         lw_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  mask_q, mask_d, rest;
  logic [PRESS_W-1:0]       press_q;
  logic                     hb_q;
  logic [CH_W-1:0]          sel_ch;
  logic [VAL_W-1:0]         sel_val;
  logic                     slot_free;

  logic                     valid_q, write_q, last_q, hbo_q;
  logic [CH_W-1:0]          ch_q;
  logic [SEL_LOW_W-1:0]     sl_q;
  logic [SEL_HIGH_W-1:0]    sh_q;
  logic [PRESS_W-1:0]       val_q;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign slot_free = !valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      mask_d[i] = (want_value(CH_W'(i), head_i.pressure) != lw_q[i]);
    end
  end

  always_comb begin
    sel_ch = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_ch = CH_W'(i);
      end
    end
  end

  assign rest    = mask_q & (mask_q - NUM_CHANNELS'(1));
  assign sel_val = want_value(sel_ch, press_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lw_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_ready_i) begin
            valid_q <= 1'b0;
          end
          if (!empty_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot_free) begin
            valid_q <= 1'b1;
            if (mask_q == '0 || rest == '0) begin
              state_q <= ST_IDLE;
            end
            if (mask_q != '0) begin
              lw_q[sel_ch[IdxW-1:0]] <= sel_val;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mask_q  <= mask_d;
      press_q <= head_i.pressure;
      hb_q    <= head_i.heartbeat;
    end else if (state_q == ST_SCAN && slot_free) begin
      mask_q <= rest;
    end
    if (state_q == ST_SCAN && slot_free) begin
      hbo_q <= hb_q;
      if (mask_q == '0) begin
        write_q <= 1'b0;
        ch_q    <= '0;
        sl_q    <= '0;
        sh_q    <= '0;
        val_q   <= '0;
        last_q  <= 1'b1;
      end else begin
        write_q <= 1'b1;
        ch_q    <= sel_ch;
        sl_q    <= sel_low(sel_ch);
        sh_q    <= sel_high(sel_ch);
        val_q   <= sel_val[PRESS_W-1:0];
        last_q  <= (rest == '0);
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign out_write_o     = write_q;
  assign out_channel_o   = ch_q;
  assign out_sel_low_o   = sl_q;
  assign out_sel_high_o  = sh_q;
  assign out_value_o     = val_q;
  assign out_heartbeat_o = hbo_q;
  assign out_last_o      = last_q;

endmodule

@@ hw/rtl/pressure_profile_dac_sequencer.sv @@
// path: a tick enters the queue at its acceptance edge; the idle scanner pops it into
// its mask register, then registers its first result once the output slot is free
// flow: the scanner loads a tick only in its idle state, then sends one to NUM_CHANNELS
// results for it in turn while the output accepts them; the front takes one tick a cycle
// until the two-entry queue fills
// reset: phase base, countdown and heartbeat zero, last written values zero, queue
// empty, registers at their reset values
// ----------------------------------------------------------------------------
// pressure_profile_dac_sequencer
// timer driven pressure profile with change-only dac channel writes
// ----------------------------------------------------------------------------
module pressure_profile_dac_sequencer #(
  parameter int unsigned NUM_CHANNELS     = 14,
  parameter int unsigned TICKS_PER_SECOND = 80,
  parameter int unsigned HEARTBEAT_TICKS  = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // start_req, reset_req, zero fill
  input  logic [ppds_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // channel, select_low, select_high, dac_value, heartbeat
  output logic [ppds_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // write_valid
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppds_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ppds_pkg::*;

  logic                  push, full, pop, empty;
  tick_t                 entry, head;
  logic [CH_W-1:0]       channel;
  logic [SEL_LOW_W-1:0]  select_low;
  logic [SEL_HIGH_W-1:0] select_high;
  logic [PRESS_W-1:0]    dac_value;
  logic                  heartbeat;

  assign cfg_ready_o = 1'b1;

  ppds_front #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .HEARTBEAT_TICKS (HEARTBEAT_TICKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_valid_i(s_axis_tvalid_i),
    .start_req_i (s_axis_tdata_i[0]),
    .reset_req_i (s_axis_tdata_i[1]),
    .tick_ready_o(s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (entry),
    .full_i      (full)
  );

  ppds_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  ppds_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_write_o    (m_axis_tuser_o),
    .out_channel_o  (channel),
    .out_sel_low_o  (select_low),
    .out_sel_high_o (select_high),
    .out_value_o    (dac_value),
    .out_heartbeat_o(heartbeat),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {heartbeat, dac_value, select_high, select_low, channel};

  a_status_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("status result without last");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[30:0] == '0))
    else $error("status result carries write fields");

  a_select_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0({select_high, select_low}))
    else $error("more than one chip select");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("tick pushed into a full queue");

endmodule
